@@ sv/fra_pkg.sv @@
package fra_pkg;

   // Default sizes handed to the top level.
   localparam int NUM_CPUS_DEF   = 8;
   localparam int NUM_STATES_DEF = 16;

   // Most results that one read returns.
   localparam int MAX_OUT = 16;

   // Operation codes carried in the request tuser.
   localparam logic [2:0] OP_LOAD    = 3'd0;
   localparam logic [2:0] OP_COMMIT  = 3'd1;
   localparam logic [2:0] OP_FREQ    = 3'd2;
   localparam logic [2:0] OP_ONLINE  = 3'd3;
   localparam logic [2:0] OP_OFFLINE = 3'd4;
   localparam logic [2:0] OP_READ    = 3'd5;
   localparam logic [2:0] OP_CLEAR   = 3'd6;
   localparam logic [2:0] OP_ENABLE  = 3'd7;

endpackage

@@ sv/frequency_residency_accounting.sv @@
// Channel  Direction  tdata / tuser / tlast
// req      in         tdata: cpu, cpu_mask, online_mask, entry_index, state_count, freq, now,
//                     enable_value; tuser: opcode
// rsp      out        tdata: out_freq, residency, state_slot; tuser: valid_res; tlast: last
//
// One word is taken at a time. Load, online, enable and no-op words are handled in the idle state.
// Commit clears the NUM_STATES counters of its CPU, then searches the frequency table,
// reading and then comparing one slot at a time until a slot matches or none is left.
// A frequency change walks the CPUs in turn; each masked online CPU gets a counter
// update first, which credits its counter when it sits in a known slot, and then every
// masked CPU searches the table. A read takes the counter update and then reads out
// and sends its result words one after another.
// Reset, and a clear word with enable_value set, run a clearing pass over all
// NUM_CPUS*NUM_STATES entries of the residency memory.
// A stalled result port holds the sequencer only while a further result word is due.
module frequency_residency_accounting #(
   parameter int NUM_CPUS   = fra_pkg::NUM_CPUS_DEF,
   parameter int NUM_STATES = fra_pkg::NUM_STATES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cpu, cpu_mask, online_mask, entry_index, state_count, freq, now, enable_value
   input  logic [127:0] req_tdata,
   // opcode
   input  logic [2:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_freq, residency, state_slot
   output logic [103:0] rsp_tdata,
   // valid_res
   output logic         rsp_tuser,
   output logic         rsp_tlast
);

   localparam int TOTAL = NUM_CPUS * NUM_STATES;
   localparam int AW    = $clog2(TOTAL);
   localparam int CW    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int SW    = $clog2(NUM_STATES);
   localparam int SCW   = $clog2(NUM_STATES + 1);
   localparam int FC_END = (NUM_CPUS < 8) ? NUM_CPUS : 8;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_CLR_ALL = 4'd1;
   localparam logic [3:0] ST_CLR_ROW = 4'd2;
   localparam logic [3:0] ST_LK_RD   = 4'd3;
   localparam logic [3:0] ST_LK_CMP  = 4'd4;
   localparam logic [3:0] ST_ADV_RD  = 4'd5;
   localparam logic [3:0] ST_ADV_WR  = 4'd6;
   localparam logic [3:0] ST_FC_NEXT = 4'd7;
   localparam logic [3:0] ST_EM_RD   = 4'd8;
   localparam logic [3:0] ST_EM_WAIT = 4'd9;
   localparam logic [3:0] ST_EM_ONE  = 4'd10;

   // Input word fields.
   logic [2:0]  f_opcode;
   logic [2:0]  f_cpu;
   logic [7:0]  f_mask;
   logic [7:0]  f_onl;
   logic [3:0]  f_idx;
   logic [4:0]  f_cnt;
   logic [31:0] f_freq;
   logic [63:0] f_now;
   logic        f_en;

   assign f_opcode = req_tuser;
   assign f_cpu    = req_tdata[2:0];
   assign f_mask   = req_tdata[10:3];
   assign f_onl    = req_tdata[18:11];
   assign f_idx    = req_tdata[22:19];
   assign f_cnt    = req_tdata[27:23];
   assign f_freq   = req_tdata[59:28];
   assign f_now    = req_tdata[123:60];
   assign f_en     = req_tdata[124];

   // Control and per-CPU state.
   logic [3:0]     state_ff, state_in;
   logic [2:0]     op_ff, op_in;
   logic [CW-1:0]  tgt_ff, tgt_in;
   logic [7:0]     mask_ff, mask_in;
   logic [7:0]     onl_ff, onl_in;
   logic [31:0]    freq_ff, freq_in;
   logic [63:0]    now_ff, now_in;
   logic [SCW-1:0] li_ff, li_in;
   logic [SCW-1:0] n_ff, n_in;
   logic [AW-1:0]  ca_ff, ca_in;
   logic [3:0]     fc_ff, fc_in;
   logic           zv_ff, zv_in;
   logic [63:0]    delta_ff, delta_in;
   logic           collecting_ff, collecting_in;

   logic [63:0]    stamp_ff [NUM_CPUS];
   logic [63:0]    stamp_in [NUM_CPUS];
   logic [SW-1:0]  slot_ff  [NUM_CPUS];
   logic [SW-1:0]  slot_in  [NUM_CPUS];
   logic [SCW-1:0] siu_ff   [NUM_CPUS];
   logic [SCW-1:0] siu_in   [NUM_CPUS];
   logic [NUM_CPUS-1:0] slot_ok_ff, slot_ok_in;
   logic [NUM_CPUS-1:0] ready_ff, ready_in;
   logic [NUM_CPUS-1:0] running_ff, running_in;

   // Result register.
   logic         rv_ff, rv_in;
   logic [31:0]  ro_freq_ff, ro_freq_in;
   logic [63:0]  ro_res_ff, ro_res_in;
   logic [3:0]   ro_slot_ff, ro_slot_in;
   logic         ro_valid_ff, ro_valid_in;
   logic         ro_last_ff, ro_last_in;

   // Memories and their ports.
   logic [31:0] freq_mem [TOTAL];
   logic [63:0] res_mem  [TOTAL];
   logic [31:0] freq_q_ff;
   logic [63:0] res_q_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] fw_addr;
   logic          fw_en;
   logic [AW-1:0] rw_addr;
   logic          rw_en;
   logic [63:0]   rw_data;

   logic          accept;
   logic          out_free;
   logic          cpu_ok;
   logic [CW-1:0] cpu_i;
   logic [CW-1:0] fc_cpu;
   logic [AW-1:0] adv_addr;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rv_ff || rsp_tready;
   assign cpu_ok   = int'(f_cpu) < NUM_CPUS;
   assign cpu_i    = CW'(f_cpu);
   assign fc_cpu   = CW'(fc_ff);
   assign adv_addr = AW'(int'(tgt_ff) * NUM_STATES + int'(slot_ff[tgt_ff]));

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {4'd0, ro_slot_ff, ro_res_ff, ro_freq_ff};
   assign rsp_tuser  = ro_valid_ff;
   assign rsp_tlast  = ro_last_ff;

   // Read address of both memories follows the sequencer step.
   always_comb begin
      case (state_ff)
         ST_ADV_RD, ST_ADV_WR: begin
            rd_addr = adv_addr;
         end
         ST_EM_RD, ST_EM_WAIT: begin
            rd_addr = AW'(int'(tgt_ff) * NUM_STATES + int'(n_ff) * 0 + int'(li_ff));
         end
         default: begin
            rd_addr = AW'(int'(tgt_ff) * NUM_STATES + int'(li_ff));
         end
      endcase
   end

   // Frequency table writes come straight from load words.
   assign fw_en   = accept && (f_opcode == fra_pkg::OP_LOAD) && cpu_ok
                    && (int'(f_idx) < NUM_STATES);
   assign fw_addr = AW'(int'(f_cpu) * NUM_STATES + int'(f_idx));

   // Residency writes: clearing passes and the counter update.
   always_comb begin
      rw_en   = 1'b0;
      rw_addr = rd_addr;
      rw_data = '0;
      case (state_ff)
         ST_CLR_ALL: begin
            rw_en   = 1'b1;
            rw_addr = ca_ff;
         end
         ST_CLR_ROW: begin
            rw_en   = 1'b1;
            rw_addr = AW'(int'(tgt_ff) * NUM_STATES + int'(li_ff));
         end
         ST_ADV_WR: begin
            rw_en   = 1'b1;
            rw_addr = adv_addr;
            rw_data = res_q_ff + delta_ff;
         end
         default: begin
            rw_en = 1'b0;
         end
      endcase
   end

   // Frequency table memory.
   always_ff @(posedge clock) begin
      if (fw_en) begin
         freq_mem[fw_addr] <= f_freq;
      end
      freq_q_ff <= freq_mem[rd_addr];
   end

   // Residency memory.
   always_ff @(posedge clock) begin
      if (rw_en) begin
         res_mem[rw_addr] <= rw_data;
      end
      res_q_ff <= res_mem[rd_addr];
   end

   // Sequencer.
   always_comb begin
      logic adv_active;
      logic adv_hit;
      logic adv_done;
      logic lk_done;
      int   rn;

      state_in      = state_ff;
      op_in         = op_ff;
      tgt_in        = tgt_ff;
      mask_in       = mask_ff;
      onl_in        = onl_ff;
      freq_in       = freq_ff;
      now_in        = now_ff;
      li_in         = li_ff;
      n_in          = n_ff;
      ca_in         = ca_ff;
      fc_in         = fc_ff;
      zv_in         = zv_ff;
      delta_in      = delta_ff;
      collecting_in = collecting_ff;
      stamp_in      = stamp_ff;
      slot_in       = slot_ff;
      siu_in        = siu_ff;
      slot_ok_in    = slot_ok_ff;
      ready_in      = ready_ff;
      running_in    = running_ff;
      rv_in         = rv_ff && !rsp_tready;
      ro_freq_in    = ro_freq_ff;
      ro_res_in     = ro_res_ff;
      ro_slot_in    = ro_slot_ff;
      ro_valid_in   = ro_valid_ff;
      ro_last_in    = ro_last_ff;

      adv_active = collecting_ff && running_ff[tgt_ff];
      adv_hit    = adv_active && ready_ff[tgt_ff] && slot_ok_ff[tgt_ff]
                   && (int'(slot_ff[tgt_ff]) < int'(siu_ff[tgt_ff]));
      adv_done   = 1'b0;
      lk_done    = 1'b0;
      rn         = (int'(siu_ff[tgt_ff]) > fra_pkg::MAX_OUT) ? fra_pkg::MAX_OUT
                   : int'(siu_ff[tgt_ff]);

      case (state_ff)
         // Take one word and start its work.
         ST_IDLE: begin
            if (accept) begin
               op_in   = f_opcode;
               tgt_in  = cpu_i;
               mask_in = f_mask;
               onl_in  = f_onl;
               freq_in = f_freq;
               now_in  = f_now;
               case (f_opcode)
                  fra_pkg::OP_COMMIT: begin
                     if (cpu_ok && !ready_ff[cpu_i]) begin
                        siu_in[cpu_i]     = (int'(f_cnt) < NUM_STATES) ? SCW'(f_cnt)
                                            : SCW'(NUM_STATES);
                        stamp_in[cpu_i]   = f_now;
                        running_in[cpu_i] = 1'b1;
                        ready_in[cpu_i]   = 1'b1;
                        li_in             = '0;
                        state_in          = ST_CLR_ROW;
                     end
                  end
                  fra_pkg::OP_FREQ: begin
                     fc_in    = '0;
                     state_in = ST_FC_NEXT;
                  end
                  fra_pkg::OP_ONLINE: begin
                     if (cpu_ok) begin
                        stamp_in[cpu_i]   = f_now;
                        running_in[cpu_i] = 1'b1;
                     end
                  end
                  fra_pkg::OP_OFFLINE: begin
                     if (cpu_ok) begin
                        state_in = ST_ADV_RD;
                     end
                  end
                  fra_pkg::OP_READ: begin
                     if (cpu_ok && ready_ff[cpu_i]) begin
                        state_in = ST_ADV_RD;
                     end else begin
                        zv_in    = 1'b0;
                        state_in = ST_EM_ONE;
                     end
                  end
                  fra_pkg::OP_CLEAR: begin
                     if (f_en) begin
                        ca_in    = '0;
                        state_in = ST_CLR_ALL;
                     end
                  end
                  fra_pkg::OP_ENABLE: begin
                     if (f_en != collecting_ff) begin
                        if (f_en) begin
                           for (int c = 0; c < NUM_CPUS; c++) begin
                              if (running_ff[c]) begin
                                 stamp_in[c] = f_now;
                              end
                           end
                        end
                        collecting_in = f_en;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // Clear every counter, one entry a cycle.
         ST_CLR_ALL: begin
            ca_in = ca_ff + AW'(1);
            if (ca_ff == AW'(TOTAL - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // Clear the counters of one CPU, then look up its frequency.
         ST_CLR_ROW: begin
            li_in = li_ff + SCW'(1);
            if (int'(li_ff) == NUM_STATES - 1) begin
               li_in    = '0;
               state_in = ST_LK_RD;
            end
         end

         // Table search: read a slot, then compare it.
         ST_LK_RD: begin
            if (li_ff < siu_ff[tgt_ff]) begin
               state_in = ST_LK_CMP;
            end else begin
               slot_ok_in[tgt_ff] = 1'b0;
               lk_done            = 1'b1;
            end
         end

         ST_LK_CMP: begin
            if (freq_q_ff == freq_ff) begin
               slot_in[tgt_ff]    = SW'(li_ff);
               slot_ok_in[tgt_ff] = 1'b1;
               lk_done            = 1'b1;
            end else begin
               li_in    = li_ff + SCW'(1);
               state_in = ST_LK_RD;
            end
         end

         // Counter update: read the counter and take the elapsed ticks.
         ST_ADV_RD: begin
            delta_in = now_ff - stamp_ff[tgt_ff];
            if (adv_hit) begin
               state_in = ST_ADV_WR;
            end else begin
               if (adv_active) begin
                  stamp_in[tgt_ff] = now_ff;
               end
               adv_done = 1'b1;
            end
         end

         ST_ADV_WR: begin
            stamp_in[tgt_ff] = now_ff;
            adv_done         = 1'b1;
         end

         // Walk the CPUs of a frequency change.
         ST_FC_NEXT: begin
            if (int'(fc_ff) >= FC_END) begin
               state_in = ST_IDLE;
            end else if (mask_ff[fc_ff[2:0]]) begin
               tgt_in = fc_cpu;
               li_in  = '0;
               if (onl_ff[fc_ff[2:0]]) begin
                  state_in = ST_ADV_RD;
               end else begin
                  state_in = ST_LK_RD;
               end
            end else begin
               fc_in = fc_ff + 4'd1;
            end
         end

         // Read out one state at a time: read its entry, then send it once the result port is free.
         ST_EM_RD: begin
            state_in = ST_EM_WAIT;
         end

         ST_EM_WAIT: begin
            if (out_free) begin
               rv_in       = 1'b1;
               ro_freq_in  = freq_q_ff;
               ro_res_in   = res_q_ff;
               ro_slot_in  = 4'(li_ff);
               ro_valid_in = 1'b1;
               ro_last_in  = (li_ff + SCW'(1)) == n_ff;
               if ((li_ff + SCW'(1)) == n_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  li_in    = li_ff + SCW'(1);
                  state_in = ST_EM_RD;
               end
            end
         end

         // Single result for a CPU without table or without states.
         ST_EM_ONE: begin
            if (out_free) begin
               rv_in       = 1'b1;
               ro_freq_in  = '0;
               ro_res_in   = '0;
               ro_slot_in  = '0;
               ro_valid_in = zv_ff;
               ro_last_in  = 1'b1;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Work that follows a counter update.
      if (adv_done) begin
         case (op_ff)
            fra_pkg::OP_FREQ: begin
               stamp_in[tgt_ff]   = now_ff;
               running_in[tgt_ff] = 1'b1;
               li_in              = '0;
               state_in           = ST_LK_RD;
            end
            fra_pkg::OP_OFFLINE: begin
               stamp_in[tgt_ff]   = '0;
               running_in[tgt_ff] = 1'b0;
               state_in           = ST_IDLE;
            end
            default: begin
               n_in  = SCW'(rn);
               li_in = '0;
               if (rn == 0) begin
                  zv_in    = 1'b1;
                  state_in = ST_EM_ONE;
               end else begin
                  state_in = ST_EM_RD;
               end
            end
         endcase
      end

      // Work that follows a table search.
      if (lk_done) begin
         if (op_ff == fra_pkg::OP_FREQ) begin
            fc_in    = fc_ff + 4'd1;
            state_in = ST_FC_NEXT;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLR_ALL;
         ca_ff         <= '0;
         collecting_ff <= 1'b1;
         ready_ff      <= '0;
         running_ff    <= '0;
         slot_ok_ff    <= '0;
         rv_ff         <= 1'b0;
         for (int c = 0; c < NUM_CPUS; c++) begin
            siu_ff[c]   <= '0;
            stamp_ff[c] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         ca_ff         <= ca_in;
         collecting_ff <= collecting_in;
         ready_ff      <= ready_in;
         running_ff    <= running_in;
         slot_ok_ff    <= slot_ok_in;
         rv_ff         <= rv_in;
         siu_ff        <= siu_in;
         stamp_ff      <= stamp_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      tgt_ff      <= tgt_in;
      mask_ff     <= mask_in;
      onl_ff      <= onl_in;
      freq_ff     <= freq_in;
      now_ff      <= now_in;
      li_ff       <= li_in;
      n_ff        <= n_in;
      fc_ff       <= fc_in;
      zv_ff       <= zv_in;
      delta_ff    <= delta_in;
      slot_ff     <= slot_in;
      ro_freq_ff  <= ro_freq_in;
      ro_res_ff   <= ro_res_in;
      ro_slot_ff  <= ro_slot_in;
      ro_valid_ff <= ro_valid_in;
      ro_last_ff  <= ro_last_in;
   end

endmodule

@@ dv/tb_frequency_residency_accounting.sv @@
`timescale 1ns / 100ps

module tb_frequency_residency_accounting;

   localparam int CPUS       = fra_pkg::NUM_CPUS_DEF;
   localparam int STATES     = fra_pkg::NUM_STATES_DEF;
   localparam int IDLE_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;
   localparam logic [4:0] SLOT_INVALID = 5'h1F;

   // One request word, split into its fields.
   typedef struct packed {
      logic [2:0]  op;
      logic [2:0]  cpu;
      logic [7:0]  mask;
      logic [7:0]  onl;
      logic [3:0]  idx;
      logic [4:0]  cnt;
      logic [31:0] freq;
      logic [63:0] now;
      logic        en;
   } req_word_type;

   // One expected result word.
   typedef struct packed {
      logic [31:0] freq;
      logic [63:0] res;
      logic [3:0]  slot;
      logic        vld;
      logic        last;
   } state_report_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic [2:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;

   frequency_residency_accounting dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   // Shadow copy of the accounting state.
   logic [31:0] shadow_freq [CPUS][STATES];
   logic [63:0] residency  [CPUS][STATES];
   logic [63:0] stamp_q    [CPUS];
   logic [4:0]  cur_slot   [CPUS];
   logic [4:0]  n_states   [CPUS];
   logic        committed  [CPUS];
   logic        cpu_running[CPUS];
   logic        collecting;

   state_report_type pending_reports[$];
   logic [63:0]   tick;
   int            errors;
   int            words_sent;
   int            reports_seen;
   int            idle_cycles;
   bit            quiet;
   bit            hold_req;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Mismatch report.
   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic logic [4:0] find_slot(input int c, input logic [31:0] f);
      for (int i = 0; i < STATES; i++) begin
         if (i < n_states[c] && shadow_freq[c][i] == f) return 5'(i);
      end
      return SLOT_INVALID;
   endfunction

   // Credit elapsed ticks to the current state of a CPU.
   task automatic accrue(input int c, input logic [63:0] now);
      if (!collecting || !cpu_running[c]) return;
      if (committed[c] && cur_slot[c] < n_states[c] && cur_slot[c] < STATES)
         residency[c][cur_slot[c]] += now - stamp_q[c];
      stamp_q[c] = now;
   endtask

   // Apply one word to the shadow state and queue the reports it causes.
   task automatic predict_residency(input req_word_type w);
      state_report_type r;
      int n;
      case (w.op)
         fra_pkg::OP_LOAD: shadow_freq[w.cpu][w.idx] = w.freq;
         fra_pkg::OP_COMMIT: begin
            if (!committed[w.cpu]) begin
               n_states[w.cpu] = (w.cnt < STATES) ? w.cnt : 5'(STATES);
               for (int i = 0; i < STATES; i++) residency[w.cpu][i] = '0;
               stamp_q[w.cpu] = w.now;
               cpu_running[w.cpu] = 1'b1;
               committed[w.cpu] = 1'b1;
               cur_slot[w.cpu] = find_slot(w.cpu, w.freq);
            end
         end
         fra_pkg::OP_FREQ: begin
            for (int c = 0; c < CPUS; c++) begin
               if (w.mask[c]) begin
                  if (w.onl[c]) begin
                     accrue(c, w.now);
                     stamp_q[c] = w.now;
                     cpu_running[c] = 1'b1;
                  end
                  cur_slot[c] = find_slot(c, w.freq);
               end
            end
         end
         fra_pkg::OP_ONLINE: begin
            stamp_q[w.cpu] = w.now;
            cpu_running[w.cpu] = 1'b1;
         end
         fra_pkg::OP_OFFLINE: begin
            accrue(w.cpu, w.now);
            cpu_running[w.cpu] = 1'b0;
            stamp_q[w.cpu] = '0;
         end
         fra_pkg::OP_READ: begin
            if (!committed[w.cpu]) begin
               r = '{freq: '0, res: '0, slot: '0, vld: 1'b0, last: 1'b1};
               pending_reports.push_back(r);
            end else begin
               accrue(w.cpu, w.now);
               n = (n_states[w.cpu] > fra_pkg::MAX_OUT) ? fra_pkg::MAX_OUT : n_states[w.cpu];
               if (n == 0) begin
                  r = '{freq: '0, res: '0, slot: '0, vld: 1'b1, last: 1'b1};
                  pending_reports.push_back(r);
               end
               for (int i = 0; i < n; i++) begin
                  r.freq = shadow_freq[w.cpu][i];
                  r.res  = residency[w.cpu][i];
                  r.slot = 4'(i);
                  r.vld  = 1'b1;
                  r.last = (i + 1 == n);
                  pending_reports.push_back(r);
               end
            end
         end
         fra_pkg::OP_CLEAR: begin
            if (w.en)
               for (int c = 0; c < CPUS; c++)
                  for (int i = 0; i < STATES; i++) residency[c][i] = '0;
         end
         default: begin
            if (w.en != collecting) begin
               if (w.en)
                  for (int c = 0; c < CPUS; c++)
                     if (cpu_running[c]) stamp_q[c] = w.now;
               collecting = w.en;
            end
         end
      endcase
   endtask

   // Offer one word, wait for its acceptance, then maybe leave a gap.
   task automatic send_word(input req_word_type w);
      predict_residency(w);
      req_tvalid <= 1'b1;
      req_tuser  <= w.op;
      req_tdata  <= {3'b0, w.en, w.now, w.freq, w.cnt, w.idx, w.onl, w.mask, w.cpu};
      do @(posedge clock); while (!req_tready);
      words_sent++;
      if (!quiet && $urandom_range(3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   function automatic req_word_type make_word(input logic [2:0] op, input logic [2:0] cpu);
      req_word_type w;
      w = '0;
      w.op  = op;
      w.cpu = cpu;
      w.now = tick;
      return w;
   endfunction

   // Advance the time stamp and send a simple per-CPU word.
   task automatic send_op(input logic [2:0] op, input logic [2:0] cpu);
      tick += 64'($urandom_range(1, 5000));
      send_word(make_word(op, cpu));
   endtask

   task automatic send_freq(input logic [7:0] mask, input logic [7:0] onl,
                            input logic [31:0] f);
      req_word_type w;
      tick += 64'($urandom_range(1, 5000));
      w = make_word(fra_pkg::OP_FREQ, 3'($urandom));
      w.mask = mask;
      w.onl  = onl;
      w.freq = f;
      send_word(w);
   endtask

   task automatic send_en(input logic [2:0] op, input logic en);
      req_word_type w;
      tick += 64'($urandom_range(1, 5000));
      w = make_word(op, 3'($urandom));
      w.en = en;
      send_word(w);
   endtask

   function automatic logic [31:0] slot_freq(input int c, input int i);
      if (c == 3 && i == 0) return 32'h0;
      if (c == 4 && i == 1) return 32'hFFFF_FFFF;
      if (c == 6 && i == 2) return 32'(100000 * 2);
      return 32'(100000 * (i + 1));
   endfunction

   // A CPU without a table answers with a single empty word.
   task automatic test_no_table();
      send_op(fra_pkg::OP_READ, 3'd3);
      send_op(fra_pkg::OP_ONLINE, 3'd3);
      send_op(fra_pkg::OP_OFFLINE, 3'd3);
   endtask

   // Load every table up to its state count or STATES, whichever is less, and commit it.
   task automatic test_setup_tables();
      int counts[CPUS] = '{0, 20, 16, 1, 2, 3, 5, 8};
      req_word_type w;
      for (int c = 0; c < CPUS; c++) begin
         for (int i = 0; i < counts[c] && i < STATES; i++) begin
            w = make_word(fra_pkg::OP_LOAD, 3'(c));
            w.idx  = 4'(i);
            w.freq = slot_freq(c, i);
            send_word(w);
         end
         tick += 64'($urandom_range(1, 5000));
         w = make_word(fra_pkg::OP_COMMIT, 3'(c));
         w.cnt  = 5'(counts[c]);
         w.freq = slot_freq(c, 0);
         send_word(w);
      end
   endtask

   // Empty table, oversized table, and a repeated commit that is ignored.
   task automatic test_read_extremes();
      req_word_type w;
      send_op(fra_pkg::OP_READ, 3'd0);
      send_op(fra_pkg::OP_READ, 3'd1);
      w = make_word(fra_pkg::OP_COMMIT, 3'd1);
      w.cnt = 5'd15;
      send_word(w);
      send_op(fra_pkg::OP_READ, 3'd1);
   endtask

   // Frequency changes: matched, duplicated, unmatched, and offline CPUs in the mask.
   task automatic test_rate_changes();
      send_freq(8'hFF, 8'hFF, 32'(200000));
      send_freq(8'hA5, 8'h0F, 32'hFFFF_FFFF);
      send_freq(8'hFF, 8'hFF, 32'h0);
      send_freq(8'h5A, 8'hFF, 32'h1234_5678);
      send_op(fra_pkg::OP_READ, 3'd6);
   endtask

   // Hotplug around reads.
   task automatic test_hotplug();
      send_op(fra_pkg::OP_OFFLINE, 3'd2);
      send_freq(8'h04, 8'h00, 32'(300000));
      send_op(fra_pkg::OP_READ, 3'd2);
      send_op(fra_pkg::OP_ONLINE, 3'd2);
      send_op(fra_pkg::OP_READ, 3'd2);
   endtask

   // Collection off and on, and both clear variants.
   task automatic test_enable_and_clear();
      send_en(fra_pkg::OP_ENABLE, 1'b0);
      send_freq(8'hFF, 8'hFF, 32'(100000));
      send_en(fra_pkg::OP_ENABLE, 1'b0);
      send_op(fra_pkg::OP_READ, 3'd7);
      send_en(fra_pkg::OP_ENABLE, 1'b1);
      send_en(fra_pkg::OP_ENABLE, 1'b1);
      send_en(fra_pkg::OP_CLEAR, 1'b0);
      send_op(fra_pkg::OP_READ, 3'd5);
      send_en(fra_pkg::OP_CLEAR, 1'b1);
      send_op(fra_pkg::OP_READ, 3'd5);
   endtask

   // Timestamps that wrap around the top of the 64-bit range.
   task automatic test_timestamp_wrap();
      tick = 64'hFFFF_FFFF_FFFF_F000;
      send_freq(8'hFF, 8'hFF, 32'(100000));
      tick = 64'h0;
      send_op(fra_pkg::OP_READ, 3'd4);
   endtask

   // Hold off the result side for a long stretch while reads keep arriving.
   task automatic test_backpressure();
      hold_req = 1'b1;
      repeat (8) send_op(fra_pkg::OP_READ, 3'd1);
   endtask

   // Mostly meaningful traffic with random content, some noise.
   task automatic send_random(input int count);
      req_word_type w;
      int pick;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         tick += ($urandom_range(15) == 0) ? {$urandom, $urandom}
                                            : 64'($urandom_range(1, 20000));
         w = make_word(fra_pkg::OP_FREQ, 3'($urandom));
         w.mask = 8'($urandom);
         w.onl  = 8'($urandom);
         w.idx  = 4'($urandom);
         w.cnt  = 5'($urandom_range(0, 31));
         w.en   = 1'($urandom);
         case ($urandom_range(3))
            0: w.freq = $urandom;
            1: w.freq = ($urandom_range(1)) ? 32'h0 : 32'hFFFF_FFFF;
            default: w.freq = 32'(100000 * $urandom_range(1, 16));
         endcase
         if (pick < 35) w.op = fra_pkg::OP_FREQ;
         else if (pick < 55) w.op = fra_pkg::OP_READ;
         else if (pick < 65) w.op = fra_pkg::OP_ONLINE;
         else if (pick < 75) w.op = fra_pkg::OP_OFFLINE;
         else if (pick < 83) w.op = fra_pkg::OP_LOAD;
         else if (pick < 86) w.op = fra_pkg::OP_COMMIT;
         else if (pick < 91) begin
            w.op = fra_pkg::OP_CLEAR;
            w.en = ($urandom_range(3) == 0);
         end else w.op = fra_pkg::OP_ENABLE;
         send_word(w);
      end
   endtask

   // Result side: random stalls, one long hold on request, none at the end.
   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else if (quiet) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // Compare each result word with the oldest expectation.
   always @(posedge clock) begin
      state_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         reports_seen++;
         if (pending_reports.size() == 0) begin
            report("unexpected word", 64'({rsp_tuser, rsp_tlast}), 64'd0);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_tdata[31:0] !== want.freq)
               report("out_freq", 64'(rsp_tdata[31:0]), 64'(want.freq));
            if (rsp_tdata[95:32] !== want.res)
               report("residency", rsp_tdata[95:32], want.res);
            if (rsp_tdata[99:96] !== want.slot)
               report("state_slot", 64'(rsp_tdata[99:96]), 64'(want.slot));
            if (rsp_tuser !== want.vld) report("valid_res", 64'(rsp_tuser), 64'(want.vld));
            if (rsp_tlast !== want.last) report("last", 64'(rsp_tlast), 64'(want.last));
         end
      end
   end

   // Watchdog on cycles with no transfer on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout with %0d words outstanding", pending_reports.size());
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Test sequence.
   initial begin
      errors = 0;
      words_sent = 0;
      reports_seen = 0;
      idle_cycles = 0;
      quiet = 1'b0;
      hold_req = 1'b0;
      tick = 64'd1000;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      for (int c = 0; c < CPUS; c++) begin
         for (int i = 0; i < STATES; i++) residency[c][i] = '0;
         stamp_q[c] = '0;
         cur_slot[c] = SLOT_INVALID;
         n_states[c] = '0;
         committed[c] = 1'b0;
         cpu_running[c] = 1'b0;
      end
      collecting = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_no_table();
      test_setup_tables();
      test_read_extremes();
      test_rate_changes();
      test_hotplug();
      test_enable_and_clear();
      test_timestamp_wrap();
      test_backpressure();
      send_random(15);
      quiet = 1'b1;
      send_random(15);
      req_tvalid <= 1'b0;

      while (pending_reports.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("Sent %0d request words and checked %0d result words.", words_sent, reports_seen);
      $display("Covered table setup, rate changes, hotplug, enable, clears and stalls.");
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
